>>> sv/ncsd_pkg.sv
// Shared types and constants for the normalized correlation sync detector.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package ncsd_pkg;

  localparam int REF_LEN_DEFAULT     = 128;
  localparam int SAMPLE_BITS_DEFAULT = 16;

  localparam int          SEEN_W   = 24;
  localparam logic [SEEN_W-1:0] SEEN_MAX = 24'hFFFFFF;
  localparam int          THR_W    = 15;
  localparam logic [THR_W-1:0] CORR_THRESHOLD_RESET = 15'd28508;
  // The threshold squared carries 30 fraction bits, so the correlation side is scaled to match.
  localparam int          THR_SQ_W = 2 * THR_W;

  // Configuration register addresses (bit 2 of the byte address selects the register).
  localparam logic CFG_REG_THRESHOLD = 1'b0;

  // Item operation codes.
  localparam logic [1:0] OP_LOAD_REF = 2'd0;
  localparam logic [1:0] OP_SAMPLE   = 2'd1;
  localparam logic [1:0] OP_RESTART  = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] sample_re;
    logic signed [15:0] sample_im;
    logic [6:0]         ref_index;
  } in_word_t;

  typedef struct packed {
    logic              detected;
    logic [SEEN_W-1:0] shift_position;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ENERGY,
    ST_E_DRAIN,
    ST_CORR,
    ST_C_DRAIN,
    ST_SQ_RE,
    ST_SQ_IM,
    ST_TEX,
    ST_TER,
    ST_RESULT
  } ctl_state_t;

  typedef enum logic [1:0] {
    MUL_CRE,
    MUL_CIM,
    MUL_TEX,
    MUL_TER
  } mul_sel_t;

  typedef struct packed {
    logic     accept;
    logic     scan_start;
    logic     scan_step;
    logic     energy;
    logic     er_latch;
    logic     mul_load;
    logic     mul_clear;
    mul_sel_t mul_sel;
    logic     mul_step;
    logic     lhs_latch;
    logic     out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       win_full;
    logic       scan_last;
    logic       pipe_busy;
    logic       mul_done;
    logic       out_free;
  } ctl_stat_t;

endpackage

`default_nettype wire

>>> sv/ncsd_ctrl.sv
// Sequencing state machine of the sync detector.
// Depends on ncsd_pkg; drives commands to ncsd_datapath and reads its status.
`default_nettype none

module ncsd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire ncsd_pkg::ctl_stat_t stat,
  output ncsd_pkg::ctl_cmd_t     cmd
);

  ncsd_pkg::ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ncsd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_stall = (state != ncsd_pkg::ST_IDLE);
    case (state)
      ncsd_pkg::ST_IDLE: begin
        if (item_valid) begin
          cmd.accept = 1'b1;
          if (stat.op == ncsd_pkg::OP_RESTART) begin
            cmd.scan_start = 1'b1;
            state_next     = ncsd_pkg::ST_ENERGY;
          end else if (stat.op == ncsd_pkg::OP_SAMPLE && stat.win_full) begin
            cmd.scan_start = 1'b1;
            state_next     = ncsd_pkg::ST_CORR;
          end
        end
      end
      ncsd_pkg::ST_ENERGY: begin
        cmd.energy    = 1'b1;
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_next = ncsd_pkg::ST_E_DRAIN;
        end
      end
      ncsd_pkg::ST_E_DRAIN: begin
        cmd.energy = 1'b1;
        if (!stat.pipe_busy) begin
          cmd.er_latch = 1'b1;
          state_next   = ncsd_pkg::ST_IDLE;
        end
      end
      ncsd_pkg::ST_CORR: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_next = ncsd_pkg::ST_C_DRAIN;
        end
      end
      ncsd_pkg::ST_C_DRAIN: begin
        if (!stat.pipe_busy) begin
          cmd.mul_load  = 1'b1;
          cmd.mul_clear = 1'b1;
          cmd.mul_sel   = ncsd_pkg::MUL_CRE;
          state_next    = ncsd_pkg::ST_SQ_RE;
        end
      end
      ncsd_pkg::ST_SQ_RE: begin
        if (stat.mul_done) begin
          cmd.mul_load = 1'b1;
          cmd.mul_sel  = ncsd_pkg::MUL_CIM;
          state_next   = ncsd_pkg::ST_SQ_IM;
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      ncsd_pkg::ST_SQ_IM: begin
        if (stat.mul_done) begin
          cmd.lhs_latch = 1'b1;
          cmd.mul_load  = 1'b1;
          cmd.mul_clear = 1'b1;
          cmd.mul_sel   = ncsd_pkg::MUL_TEX;
          state_next    = ncsd_pkg::ST_TEX;
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      ncsd_pkg::ST_TEX: begin
        if (stat.mul_done) begin
          cmd.mul_load  = 1'b1;
          cmd.mul_clear = 1'b1;
          cmd.mul_sel   = ncsd_pkg::MUL_TER;
          state_next    = ncsd_pkg::ST_TER;
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      ncsd_pkg::ST_TER: begin
        if (stat.mul_done) begin
          state_next = ncsd_pkg::ST_RESULT;
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      ncsd_pkg::ST_RESULT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ncsd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ncsd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/ncsd_datapath.sv
// Datapath of the sync detector: reference and window memories, the complex
// multiply-accumulate pipeline, a shift-add multiplier and the result register.
// Depends on ncsd_pkg; commanded by ncsd_ctrl.
`default_nettype none

module ncsd_datapath #(
  parameter int REF_LEN     = ncsd_pkg::REF_LEN_DEFAULT,
  parameter int SAMPLE_BITS = ncsd_pkg::SAMPLE_BITS_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ncsd_pkg::in_word_t            item,
  input  wire logic [ncsd_pkg::THR_W-1:0]    threshold,
  input  wire ncsd_pkg::ctl_cmd_t            cmd,
  output ncsd_pkg::ctl_stat_t                stat,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output ncsd_pkg::out_word_t                result
);

  localparam int SB = SAMPLE_BITS;
  localparam int LG = $clog2(REF_LEN);
  localparam int AW = LG;
  localparam int PW = 2 * SB;
  localparam int CW = 2 * SB + LG + 1;
  localparam int MW = 2 * SB + LG;
  localparam int BW = 2 * MW + ncsd_pkg::THR_SQ_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(REF_LEN - 1);

  logic [PW-1:0] ref_mem [REF_LEN];
  logic [PW-1:0] win_mem [REF_LEN];
  logic [PW-1:0] ref_q, win_q;

  logic [AW-1:0] head, head_inc, ref_ptr, win_ptr, win_ptr_inc;
  logic [ncsd_pkg::SEEN_W-1:0] seen, seen_inc;

  logic [SB-1:0] s_re, s_im;
  logic          ref_hit, wr_ref, wr_win;

  logic v1, v2;
  logic signed [SB-1:0] rr, ri, xr, xi;
  logic signed [PW-1:0] p_rr, p_ii, p_ir, p_ri, p_xx, p_yy;
  logic signed [CW-1:0] cre_acc, cim_acc;
  logic [MW-1:0] ex_acc, er;
  logic [MW-1:0] cre_mag, cim_mag;
  logic [ncsd_pkg::THR_SQ_W-1:0] tsq;

  logic [BW-1:0] ma, prod, lhs;
  logic [MW-1:0] mb;

  // Samples are taken from the low SAMPLE_BITS bits of each field.
  assign s_re    = SB'($unsigned(item.sample_re));
  assign s_im    = SB'($unsigned(item.sample_im));
  assign ref_hit = 32'(item.ref_index) < 32'(REF_LEN);
  assign wr_ref  = cmd.accept && item.op == ncsd_pkg::OP_LOAD_REF && ref_hit;
  assign wr_win  = cmd.accept && item.op == ncsd_pkg::OP_SAMPLE;

  assign head_inc    = (head == LAST_ADDR) ? '0 : head + AW'(1);
  assign win_ptr_inc = (win_ptr == LAST_ADDR) ? '0 : win_ptr + AW'(1);
  assign seen_inc    = (seen == ncsd_pkg::SEEN_MAX) ? seen : seen + 24'd1;

  always_ff @(posedge clk) begin
    if (wr_ref) begin
      ref_mem[AW'(item.ref_index)] <= {s_re, s_im};
    end
    ref_q <= ref_mem[ref_ptr];
  end

  always_ff @(posedge clk) begin
    if (wr_win) begin
      win_mem[head] <= {s_re, s_im};
    end
    win_q <= win_mem[win_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      seen <= '0;
    end else if (cmd.accept && item.op == ncsd_pkg::OP_RESTART) begin
      head <= '0;
      seen <= '0;
    end else if (wr_win) begin
      head <= head_inc;
      seen <= seen_inc;
    end
  end

  // Scan pointers: the window is read oldest first, starting at the new head.
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      ref_ptr <= '0;
      win_ptr <= head_inc;
    end else if (cmd.scan_step) begin
      ref_ptr <= (ref_ptr == LAST_ADDR) ? '0 : ref_ptr + AW'(1);
      win_ptr <= win_ptr_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.scan_step;
      v2 <= v1;
    end
  end

  assign rr = signed'(ref_q[PW-1:SB]);
  assign ri = signed'(ref_q[SB-1:0]);
  assign xr = cmd.energy ? rr : signed'(win_q[PW-1:SB]);
  assign xi = cmd.energy ? ri : signed'(win_q[SB-1:0]);

  always_ff @(posedge clk) begin
    if (v1) begin
      p_rr <= xr * rr;
      p_ii <= xi * ri;
      p_ir <= xi * rr;
      p_ri <= xr * ri;
      p_xx <= xr * xr;
      p_yy <= xi * xi;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      cre_acc <= '0;
      cim_acc <= '0;
      ex_acc  <= '0;
    end else if (v2) begin
      cre_acc <= cre_acc + CW'(p_rr) + CW'(p_ii);
      cim_acc <= cim_acc + CW'(p_ir) - CW'(p_ri);
      ex_acc  <= ex_acc + MW'($unsigned(p_xx)) + MW'($unsigned(p_yy));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      er <= '0;
    end else if (cmd.er_latch) begin
      er <= ex_acc;
    end
  end

  assign cre_mag = cre_acc[CW-1] ? MW'(-cre_acc) : MW'(cre_acc);
  assign cim_mag = cim_acc[CW-1] ? MW'(-cim_acc) : MW'(cim_acc);
  assign tsq     = ncsd_pkg::THR_SQ_W'(threshold) * ncsd_pkg::THR_SQ_W'(threshold);

  // Shift-add multiplier, one bit of the multiplier per cycle.
  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      case (cmd.mul_sel)
        ncsd_pkg::MUL_CRE: begin
          ma <= BW'(cre_mag);
          mb <= cre_mag;
        end
        ncsd_pkg::MUL_CIM: begin
          ma <= BW'(cim_mag);
          mb <= cim_mag;
        end
        ncsd_pkg::MUL_TEX: begin
          ma <= BW'(tsq);
          mb <= ex_acc;
        end
        ncsd_pkg::MUL_TER: begin
          ma <= prod;
          mb <= er;
        end
        default: begin
          ma <= '0;
          mb <= '0;
        end
      endcase
    end else if (cmd.mul_step) begin
      ma <= ma << 1;
      mb <= mb >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_clear) begin
      prod <= '0;
    end else if (cmd.mul_step && mb[0]) begin
      prod <= prod + ma;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lhs_latch) begin
      lhs <= prod << ncsd_pkg::THR_SQ_W;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.detected       <= (lhs > prod) && (ex_acc != '0) && (er != '0);
      result.shift_position <= seen - ncsd_pkg::SEEN_W'(REF_LEN);
    end
  end

  always_comb begin
    stat.op        = item.op;
    stat.win_full  = seen_inc >= ncsd_pkg::SEEN_W'(REF_LEN);
    stat.scan_last = (ref_ptr == LAST_ADDR);
    stat.pipe_busy = v1 || v2;
    stat.mul_done  = (mb == '0);
    stat.out_free  = !result_valid || !result_stall;
  end

endmodule

`default_nettype wire

>>> sv/normalized_correlation_sync_detector_core.sv
// Top level of the normalized cross-correlation sync detector.
// Depends on ncsd_pkg, ncsd_ctrl and ncsd_datapath.
//
//   Channel   Handshake               Word
//   item      item_valid/item_stall   ncsd_pkg::in_word_t (op, sample, ref_index)
//   result    result_valid/result_stall ncsd_pkg::out_word_t (detected, shift_position)
//   config    APB (psel..pready)      corr_threshold at byte address 0
//
// A reference load or an ignored word is accepted in the idle state and needs no further
// states. A restart walks the reference store with one shared complex multiply-accumulate.
// A signal sample with a full window makes one correlation pass over the window, then
// four passes of the bit-serial multiplier, whose multiplier is MW bits wide with
// MW = 2*SAMPLE_BITS + clog2(REF_LEN), and then loads the result.
// Reset is synchronous; the memories are not cleared, since the window is read only
// once it has been completely refilled after a restart.
// A finished result waits in the output register while the next word is accepted;
// a stalled result holds the controller only at the point where it would overwrite it.
`default_nettype none

module normalized_correlation_sync_detector_core #(
  parameter int REF_LEN     = ncsd_pkg::REF_LEN_DEFAULT,
  parameter int SAMPLE_BITS = ncsd_pkg::SAMPLE_BITS_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_valid,
  output logic                      item_stall,
  input  wire ncsd_pkg::in_word_t   item,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output ncsd_pkg::out_word_t       result,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  ncsd_pkg::ctl_cmd_t  cmd;
  ncsd_pkg::ctl_stat_t stat;
  logic [ncsd_pkg::THR_W-1:0] corr_threshold;

  // The single register sits at byte address 0; bit 2 tells it apart from
  // addresses beyond the register list, which read as zero and ignore writes.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      corr_threshold <= ncsd_pkg::CORR_THRESHOLD_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == ncsd_pkg::CFG_REG_THRESHOLD) begin
      corr_threshold <= pwdata[ncsd_pkg::THR_W-1:0];
    end
  end

  assign prdata = (paddr[2] == ncsd_pkg::CFG_REG_THRESHOLD) ? 32'(corr_threshold) : '0;

  ncsd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  ncsd_datapath #(
    .REF_LEN     (REF_LEN),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .threshold    (corr_threshold),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

>>> sim/tb_normalized_correlation_sync_detector_core.sv
// Testbench for normalized_correlation_sync_detector_core: drives item words and APB
// threshold writes, predicts every result word and checks it. Depends on ncsd_pkg.
`timescale 1ns / 1ps

module tb_normalized_correlation_sync_detector_core;

  localparam int NREF = 128;
  // Wait after the last expected result has come, to cover the tail of the run.
  localparam int SETTLE_CYCLES = 400;
  localparam int HOLD_CYCLES = 3000;
  // The one op code that the block ignores.
  localparam logic [1:0] OP_IGNORED = 2'd3;

  logic clk;
  logic rst;
  logic item_valid;
  logic item_stall;
  ncsd_pkg::in_word_t item;
  logic result_valid;
  logic result_stall;
  ncsd_pkg::out_word_t result;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  normalized_correlation_sync_detector_core DUT (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow copy of the block state, updated as each item word is accepted.
  logic signed [15:0] sh_ref_re [NREF];
  logic signed [15:0] sh_ref_im [NREF];
  logic signed [15:0] sh_win_re [NREF];
  logic signed [15:0] sh_win_im [NREF];
  logic [38:0] sh_ref_energy;
  logic [6:0] sh_head;
  logic [23:0] sh_seen;
  logic [14:0] sh_threshold;

  ncsd_pkg::out_word_t expected_results[$];
  int mismatches;
  int n_items;
  bit quiet;       // set for the last part of the run: no idling on either side
  bit hold_req;    // asks the receiver for one long hold-off

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Works out what the block must report for one accepted item word.
  function automatic void predict_correlation(ncsd_pkg::in_word_t w);
    longint cre, cim, ex, e, xr, xi, rr, ri;
    logic [127:0] lhs, rhs, t;
    logic [6:0] p;
    ncsd_pkg::out_word_t r;
    cre = 0;
    cim = 0;
    ex = 0;
    e = 0;
    case (w.op)
      ncsd_pkg::OP_LOAD_REF: begin
        sh_ref_re[w.ref_index] = w.sample_re;
        sh_ref_im[w.ref_index] = w.sample_im;
      end
      ncsd_pkg::OP_RESTART: begin
        for (int i = 0; i < NREF; i++) begin
          e += longint'(sh_ref_re[i]) * sh_ref_re[i] + longint'(sh_ref_im[i]) * sh_ref_im[i];
          sh_win_re[i] = '0;
          sh_win_im[i] = '0;
        end
        sh_ref_energy = e[38:0];
        sh_head = '0;
        sh_seen = '0;
      end
      ncsd_pkg::OP_SAMPLE: begin
        sh_win_re[sh_head] = w.sample_re;
        sh_win_im[sh_head] = w.sample_im;
        sh_head = sh_head + 7'd1;
        if (sh_seen != ncsd_pkg::SEEN_MAX) sh_seen = sh_seen + 24'd1;
        if (sh_seen >= 24'(NREF)) begin
          // The oldest sample in the window lines up with reference entry zero.
          for (int i = 0; i < NREF; i++) begin
            p = sh_head + i[6:0];
            xr = sh_win_re[p];
            xi = sh_win_im[p];
            rr = sh_ref_re[i];
            ri = sh_ref_im[i];
            cre += xr * rr + xi * ri;
            cim += xi * rr - xr * ri;
            ex += xr * xr + xi * xi;
          end
          r.detected = 1'b0;
          if (ex != 0 && sh_ref_energy != 0) begin
            lhs = 128'((cre < 0) ? -cre : cre);
            t = 128'((cim < 0) ? -cim : cim);
            lhs = (lhs * lhs + t * t) << 30;
            rhs = 128'(sh_threshold);
            rhs = rhs * rhs;
            t = 128'(ex);
            rhs = rhs * t;
            t = 128'(sh_ref_energy);
            rhs = rhs * t;
            r.detected = lhs > rhs;
          end
          r.shift_position = sh_seen - 24'(NREF);
          expected_results = {expected_results, r};
        end
      end
      default: ;
    endcase
  endfunction

  // Offers one item word and waits for its acceptance.
  task automatic send_word(ncsd_pkg::in_word_t w);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    item_valid <= 1'b1;
    item <= w;
    do @(posedge clk); while (item_stall);
    predict_correlation(w);
    n_items++;
    if (n_items > 1100) quiet = 1'b1;
  endtask

  function automatic ncsd_pkg::in_word_t make_word(logic [1:0] op, logic [15:0] re,
                                                   logic [15:0] im, logic [6:0] idx);
    ncsd_pkg::in_word_t w;
    w.op = op;
    w.sample_re = re;
    w.sample_im = im;
    w.ref_index = idx;
    return w;
  endfunction

  function automatic logic [15:0] sat16(int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  // Stops offering words and waits until every result has come, plus the tail latency.
  task automatic drain_results;
    @(negedge clk);
    item_valid <= 1'b0;
    wait (expected_results.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write of the threshold: setup cycle, then access cycle until pready.
  task automatic write_threshold(logic [14:0] thr);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {ncsd_pkg::CFG_REG_THRESHOLD, 2'b00};
    pwdata <= {17'd0, thr};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sh_threshold = thr;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic load_reference(bit zeros);
    for (int i = 0; i < NREF; i++) begin
      if (zeros) send_word(make_word(ncsd_pkg::OP_LOAD_REF, 16'd0, 16'd0, i[6:0]));
      else send_word(make_word(ncsd_pkg::OP_LOAD_REF, 16'($urandom), 16'($urandom), i[6:0]));
    end
  endtask

  // Sends the stored reference back as signal, optionally negated, with added noise of the given size.
  task automatic send_reference_copy(int noise, bit negate);
    int re, im;
    for (int i = 0; i < NREF; i++) begin
      re = sh_ref_re[i];
      im = sh_ref_im[i];
      if (negate) begin
        re = -re;
        im = -im;
      end
      if (noise > 0) begin
        re += int'($urandom_range(0, 2 * noise)) - noise;
        im += int'($urandom_range(0, 2 * noise)) - noise;
      end
      send_word(make_word(ncsd_pkg::OP_SAMPLE, sat16(re), sat16(im), 7'($urandom)));
    end
  endtask

  task automatic send_noise(int count);
    for (int i = 0; i < count; i++)
      send_word(make_word(ncsd_pkg::OP_SAMPLE, 16'($urandom), 16'($urandom), 7'($urandom)));
  endtask

  // Zero reference energy: a correlation against an all-zero reference never detects.
  task automatic test_zero_reference_energy;
    load_reference(1'b1);
    send_word(make_word(ncsd_pkg::OP_RESTART, 16'h1234, 16'h8000, 7'h7F));
    send_noise(NREF + 2);
  endtask

  // Extremes of the sample fields in the reference, a zero window, then a matched copy.
  task automatic test_matched_detection;
    load_reference(1'b0);
    send_word(make_word(ncsd_pkg::OP_LOAD_REF, 16'h8000, 16'h8000, 7'd0));
    send_word(make_word(ncsd_pkg::OP_LOAD_REF, 16'h7FFF, 16'h7FFF, 7'd127));
    send_word(make_word(ncsd_pkg::OP_LOAD_REF, 16'h7FFF, 16'h8000, 7'd64));
    send_word(make_word(OP_IGNORED, 16'hFFFF, 16'hFFFF, 7'h7F));
    send_word(make_word(ncsd_pkg::OP_RESTART, 16'd0, 16'd0, 7'd0));
    // A window of zeros has no energy, so the first result cannot detect.
    for (int i = 0; i < NREF; i++)
      send_word(make_word(ncsd_pkg::OP_SAMPLE, 16'd0, 16'd0, 7'd0));
    send_reference_copy(0, 1'b0);
    send_word(make_word(ncsd_pkg::OP_SAMPLE, 16'h8000, 16'h7FFF, 7'd0));
    // A load does not refresh the energy; only the next restart does.
    send_word(make_word(ncsd_pkg::OP_LOAD_REF, 16'd0, 16'd0, 7'd5));
    send_noise(3);
  endtask

  // Both threshold extremes against an exact copy and its negation.
  task automatic test_threshold_extremes;
    drain_results();
    write_threshold(15'd0);
    send_word(make_word(ncsd_pkg::OP_RESTART, 16'd0, 16'd0, 7'd0));
    send_reference_copy(0, 1'b1);
    send_noise(4);
    drain_results();
    write_threshold(15'h7FFF);
    send_word(make_word(ncsd_pkg::OP_RESTART, 16'd0, 16'd0, 7'd0));
    send_reference_copy(0, 1'b0);
    send_reference_copy(200, 1'b0);
    drain_results();
    write_threshold(ncsd_pkg::CORR_THRESHOLD_RESET);
  endtask

  // The receiver holds off long enough that the output register fills and the input stalls.
  task automatic test_output_backpressure;
    hold_req = 1'b1;
    send_noise(12);
    wait (!hold_req);
  endtask

  // Restart, noise, a noisy copy of the reference, with threshold writes, loads and ignored words mixed in.
  task automatic test_random_sequences;
    int noise;
    while (n_items < 1200) begin
      if ($urandom_range(0, 3) == 0) begin
        drain_results();
        write_threshold($urandom_range(0, 3) == 0 ? 15'($urandom_range(0, 1) * 32767)
                                                  : 15'($urandom));
      end
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 8))
          send_word(make_word(ncsd_pkg::OP_LOAD_REF, 16'($urandom), 16'($urandom),
                              7'($urandom)));
      if ($urandom_range(0, 5) != 0)
        send_word(make_word(ncsd_pkg::OP_RESTART, 16'($urandom), 16'($urandom), 7'($urandom)));
      if ($urandom_range(0, 9) == 0)
        send_word(make_word(OP_IGNORED, 16'($urandom), 16'($urandom), 7'($urandom)));
      send_noise($urandom_range(0, 12));
      case ($urandom_range(0, 3))
        0: noise = 0;
        1: noise = $urandom_range(1, 3000);
        2: noise = $urandom_range(3000, 20000);
        default: noise = 65535;
      endcase
      send_reference_copy(noise, $urandom_range(0, 1));
      if ($urandom_range(0, 3) == 0)
        send_word(make_word(ncsd_pkg::OP_LOAD_REF, 16'($urandom), 16'($urandom),
                            7'($urandom)));
      send_noise($urandom_range(0, 6));
    end
  endtask

  // Receiver: random stall bursts, one long hold-off on request, none in the quiet part.
  initial begin
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        result_stall <= 1'b1;
        for (int c = 0; c < HOLD_CYCLES; c++) @(negedge clk);
        result_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(negedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  // Each accepted result word is compared with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: detected=%0d shift=%0d",
                   result.detected, result.shift_position);
      end else begin
        if (result !== expected_results[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected detected=%0d shift=%0d, got detected=%0d shift=%0d",
                     expected_results[0].detected, expected_results[0].shift_position,
                     result.detected, result.shift_position);
        end
        void'(expected_results.pop_front());
      end
    end
  end

  initial begin
    #60000000;
    $display("tb_normalized_correlation_sync_detector_core NOT OK");
    $finish;
  end

  initial begin
    mismatches = 0;
    n_items = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    item_valid = 1'b0;
    item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    for (int i = 0; i < NREF; i++) begin
      sh_ref_re[i] = '0;
      sh_ref_im[i] = '0;
      sh_win_re[i] = '0;
      sh_win_im[i] = '0;
    end
    sh_ref_energy = '0;
    sh_head = '0;
    sh_seen = '0;
    sh_threshold = ncsd_pkg::CORR_THRESHOLD_RESET;
    rst = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_zero_reference_energy();
    test_matched_detection();
    test_threshold_extremes();
    test_output_backpressure();
    test_random_sequences();
    drain_results();

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb_normalized_correlation_sync_detector_core OK");
    end else begin
      $display("tb_normalized_correlation_sync_detector_core NOT OK");
    end
    $finish;
  end

endmodule
